[hdl/tpk_pkg.sv]
// tpk_pkg: shared types and constants for the trade position keeper
// holds command codes, the position row layout and default sizes
// no dependencies

package tpk_pkg;

  localparam int ORDER_SLOTS_DEF = 65536;
  localparam int USER_SLOTS_DEF  = 1024;
  localparam int MAX_USERS       = 1024;  // user ids are 10 bits

  typedef enum logic [2:0] {
    CMD_NEW_USER  = 3'd0,
    CMD_REG_ORDER = 3'd1,
    CMD_FILL      = 3'd2,
    CMD_LOOKUP    = 3'd3,
    CMD_READ_POS  = 3'd4
  } cmd_t;

  // net position is not stored: it always equals bq - sq modulo 2^64
  typedef struct packed {
    logic [63:0] bq;
    logic [63:0] bv;
    logic [63:0] sq;
    logic [63:0] sv;
  } pos_row_t;

endpackage

[hdl/trade_position_keeper.sv]
// trade_position_keeper: order owner table and per-user position table
// both tables are synchronous memories with registered read; fill math in tpk_fill_math
// depends on tpk_pkg, tpk_fill_math
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------------------
//  command   start / busy           cmd, order_key, other_order_key, user_id, price,
//                                   qty, taker_buys
//  result    done (one-cycle pulse) found_user, net_position, bought_qty, bought_value,
//                                   sold_qty, sold_value, status
//
// new user, register order, owner lookup and read position: busy in the cycle after the
// item, done in the cycle after that; a new item can be taken while done is shown.
// fill: busy through ST_CMD, ST_TAKER, ST_TK_WR and ST_MK_WR, no result; the single read
// port of the owner table and the single write port of the position table set this
// sequence (two lookups, two row writes). commands 5 to 7 hold busy only in ST_CMD and
// give no result. after reset a clearing pass zeroes both tables; busy is high throughout.
// results are never stalled.

module trade_position_keeper import tpk_pkg::*; #(
  parameter int ORDER_SLOTS = ORDER_SLOTS_DEF,
  parameter int USER_SLOTS  = USER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic        [2:0]  cmd,
  input  logic        [31:0] order_key,
  input  logic        [31:0] other_order_key,
  input  logic        [9:0]  user_id,
  input  logic signed [31:0] price,
  input  logic        [31:0] qty,
  input  logic               taker_buys,
  output logic               done,
  output logic        [9:0]  found_user,
  output logic signed [63:0] net_position,
  output logic signed [63:0] bought_qty,
  output logic signed [63:0] bought_value,
  output logic signed [63:0] sold_qty,
  output logic signed [63:0] sold_value,
  output logic               status
);

  localparam int USER_CAP = (USER_SLOTS < MAX_USERS) ? USER_SLOTS : MAX_USERS;
  localparam int OA       = $clog2(ORDER_SLOTS);
  localparam int PA       = $clog2(USER_CAP);
  localparam int CLR_LEN  = (ORDER_SLOTS > USER_CAP) ? ORDER_SLOTS : USER_CAP;
  localparam int CW       = $clog2(CLR_LEN);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CMD   = 6'b000100,
    ST_TAKER = 6'b001000,
    ST_TK_WR = 6'b010000,
    ST_MK_WR = 6'b100000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [CW-1:0] clr_cnt;
  logic [10:0] next_user;
  logic        accept;

  cmd_t        cmd_q;
  logic [31:0] oid_q;
  logic [31:0] oid2_q;
  logic [9:0]  uid_q;
  logic [9:0]  mk_q;
  logic [9:0]  tk_q;
  pos_row_t    upd_q;

  // owner table
  logic [9:0]  owner_mem [ORDER_SLOTS];
  logic        own_we;
  logic [OA-1:0] own_wa;
  logic [OA-1:0] own_ra;
  logic [9:0]  own_wd;
  logic [9:0]  own_rd;

  // position table
  pos_row_t    pos_mem [USER_CAP];
  logic        pos_we;
  logic [PA-1:0] pos_wa;
  logic [PA-1:0] pos_ra;
  pos_row_t    pos_wd;
  pos_row_t    pos_rd;

  logic        oid_bad;
  logic        oid2_bad;
  logic        full;
  logic        uid_ok;
  logic        mk_ok;
  logic        tk_ok;
  logic        clr_own;
  logic        clr_pos;
  logic [9:0]  tk_user;
  logic        side_taker;
  pos_row_t    fill_base;
  pos_row_t    upd;
  logic        has_result;
  logic [9:0]  found_user_next;
  logic        status_next;
  logic        show_row;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign oid_bad  = (oid_q  >= 32'(ORDER_SLOTS));
  assign oid2_bad = (oid2_q >= 32'(ORDER_SLOTS));
  assign full     = (next_user >= 11'(USER_CAP));
  assign uid_ok   = ({1'b0, uid_q} < 11'(USER_CAP));
  assign mk_ok    = ({1'b0, mk_q}  < 11'(USER_CAP));
  assign tk_ok    = ({1'b0, tk_q}  < 11'(USER_CAP));
  assign clr_own  = ({1'b0, clr_cnt} < (CW+1)'(ORDER_SLOTS));
  assign clr_pos  = ({1'b0, clr_cnt} < (CW+1)'(USER_CAP));
  assign tk_user  = oid2_bad ? 10'd0 : own_rd;

  assign has_result = (cmd_q == CMD_NEW_USER) || (cmd_q == CMD_REG_ORDER) ||
                      (cmd_q == CMD_LOOKUP) || (cmd_q == CMD_READ_POS);

  // second row update of a self trade must see the first one
  assign side_taker = (state == ST_TK_WR);
  assign fill_base  = (state == ST_MK_WR && mk_q == tk_q) ? upd_q : pos_rd;

  tpk_fill_math u_fill_math (
    .clk        (clk),
    .load       (accept),
    .price      (price),
    .qty        (qty),
    .taker_buys (taker_buys),
    .side_taker (side_taker),
    .base       (fill_base),
    .upd        (upd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == CW'(CLR_LEN - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_CMD;
      ST_CMD:   state_next = (cmd_q == CMD_FILL) ? ST_TAKER : ST_IDLE;
      ST_TAKER: state_next = ST_TK_WR;
      ST_TK_WR: state_next = ST_MK_WR;
      ST_MK_WR: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory port selection
  always_comb begin
    own_we = 1'b0;
    own_wa = oid_q[OA-1:0];
    own_wd = uid_q;
    own_ra = order_key[OA-1:0];
    pos_we = 1'b0;
    pos_wa = '0;
    pos_wd = '0;
    pos_ra = user_id[PA-1:0];
    case (state)
      ST_CLEAR: begin
        own_we = clr_own;
        own_wa = clr_cnt[OA-1:0];
        own_wd = '0;
        pos_we = clr_pos;
        pos_wa = clr_cnt[PA-1:0];
      end
      ST_CMD: begin
        own_ra = oid2_q[OA-1:0];
        if (cmd_q == CMD_REG_ORDER && !oid_bad) own_we = 1'b1;
        if (cmd_q == CMD_NEW_USER && !full) begin
          pos_we = 1'b1;
          pos_wa = next_user[PA-1:0];
        end
      end
      ST_TAKER: begin
        pos_ra = tk_user[PA-1:0];
      end
      ST_TK_WR: begin
        pos_ra = mk_q[PA-1:0];
        pos_we = tk_ok;
        pos_wa = tk_q[PA-1:0];
        pos_wd = upd;
      end
      ST_MK_WR: begin
        pos_we = mk_ok;
        pos_wa = mk_q[PA-1:0];
        pos_wd = upd;
      end
      default: begin
        own_we = 1'b0;
        pos_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (own_we) owner_mem[own_wa] <= own_wd;
    own_rd <= owner_mem[own_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      next_user <= 11'd1;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_CMD) && has_result;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + CW'(1);
      if (state == ST_CMD && cmd_q == CMD_NEW_USER && !full) next_user <= next_user + 11'd1;
    end
  end

  // item fields and fill owners
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(cmd);
      oid_q  <= order_key;
      oid2_q <= other_order_key;
      uid_q  <= user_id;
    end
    if (state == ST_CMD) mk_q <= oid_bad ? 10'd0 : own_rd;
    if (state == ST_TAKER) tk_q <= tk_user;
    if (state == ST_TK_WR) upd_q <= upd;
  end

  always_comb begin
    found_user_next = '0;
    status_next     = 1'b0;
    show_row        = 1'b0;
    case (cmd_q)
      CMD_NEW_USER: begin
        found_user_next = full ? 10'd0 : next_user[9:0];
        status_next     = full;
      end
      CMD_REG_ORDER: status_next = oid_bad;
      CMD_LOOKUP: begin
        found_user_next = oid_bad ? 10'd0 : own_rd;
        status_next     = oid_bad;
      end
      CMD_READ_POS: begin
        show_row    = uid_ok;
        status_next = !uid_ok;
      end
      default: status_next = 1'b0;
    endcase
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_CMD) begin
      found_user <= found_user_next;
      status     <= status_next;
      if (show_row) begin
        net_position <= pos_rd.bq - pos_rd.sq;
        bought_qty   <= pos_rd.bq;
        bought_value <= pos_rd.bv;
        sold_qty     <= pos_rd.sq;
        sold_value   <= pos_rd.sv;
      end else begin
        net_position <= '0;
        bought_qty   <= '0;
        bought_value <= '0;
        sold_qty     <= '0;
        sold_value   <= '0;
      end
    end
  end

endmodule

[hdl/tpk_fill_math.sv]
// tpk_fill_math: fill value multiplier and position row update
// registers price * qty when an item is taken, then adds one side of the fill
// depends on tpk_pkg

module tpk_fill_math import tpk_pkg::*; (
  input  logic               clk,
  input  logic               load,
  input  logic signed [31:0] price,
  input  logic        [31:0] qty,
  input  logic               taker_buys,
  input  logic               side_taker,
  input  pos_row_t           base,
  output pos_row_t           upd
);

  logic signed [64:0] prod;
  logic        [63:0] value_q;
  logic        [63:0] qty_q;
  logic               tbuy_q;
  logic               buys;

  // signed price times unsigned qty, low 64 bits
  assign prod = $signed(price) * $signed({1'b0, qty});

  always_ff @(posedge clk) begin
    if (load) begin
      value_q <= prod[63:0];
      qty_q   <= {32'd0, qty};
      tbuy_q  <= taker_buys;
    end
  end

  assign buys = side_taker ? tbuy_q : !tbuy_q;

  always_comb begin
    upd = base;
    if (buys) begin
      upd.bq = base.bq + qty_q;
      upd.bv = base.bv + value_q;
    end else begin
      upd.sq = base.sq + qty_q;
      upd.sv = base.sv + value_q;
    end
  end

endmodule
